FILE: hdl/assert_macros.svh
// Assertion macros shared by the checker files of this block.
// Each macro takes a label, a clock, an active-low reset and the property terms.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is low
`define ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// Next-cycle implication, disabled while reset is low
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`endif

FILE: hdl/pbecs_pkg.sv
// Package for the polled bus echo-checked sender: sizes, codes and ring helpers.
// Used by the top level, the send RAM instance and the port checker.
`timescale 1ns / 1ps

package pbecs_pkg;

    localparam int STORE_DEPTH = 64;
    localparam int ADDR_W      = $clog2(STORE_DEPTH);
    localparam int PTR_MOD     = 2 * STORE_DEPTH;
    localparam int PTR_W       = $clog2(PTR_MOD);

    localparam logic [7:0] REQ_BIT = 8'h80;

    localparam int S_TDATA_W = 8;
    localparam int S_TUSER_W = 4;
    localparam int M_TDATA_W = 24;
    localparam int M_TUSER_W = 12;

    typedef logic [PTR_W-1:0]  ptr_t;
    typedef logic [ADDR_W-1:0] addr_t;

    typedef enum logic [2:0] {
        OP_LOAD      = 3'd0,
        OP_RX_BYTE   = 3'd1,
        OP_POLL      = 3'd2,
        OP_TX_READY  = 3'd3,
        OP_TX_DONE   = 3'd4,
        OP_BIT_TICK  = 3'd5,
        OP_SLOW_TICK = 3'd6,
        OP_RESPONSE  = 3'd7
    } op_t;

    typedef enum logic [2:0] {
        PH_RX        = 3'd0,
        PH_TX_ADDR   = 3'd1,
        PH_ADDR_ECHO = 3'd2,
        PH_TX_DATA   = 3'd3,
        PH_DATA_ECHO = 3'd4,
        PH_BREAK     = 3'd5
    } phase_t;

    typedef enum logic [2:0] {
        EV_NONE     = 3'd0,
        EV_POLLED   = 3'd1,
        EV_ACK      = 3'd2,
        EV_NACK     = 3'd3,
        EV_MISMATCH = 3'd4,
        EV_TIMEOUT  = 3'd5,
        EV_DROPPED  = 3'd6
    } event_t;

    typedef enum logic [1:0] {
        WAIT_NONE     = 2'd0,
        WAIT_ACK      = 2'd1,
        WAIT_RESPONSE = 2'd2
    } wait_t;

    typedef enum logic [2:0] {
        CFG_OWN_ADDRESS     = 3'd0,
        CFG_ACK_CODE        = 3'd1,
        CFG_NACK_CODE       = 3'd2,
        CFG_TIMEOUT_TICKS   = 3'd3,
        CFG_BREAK_BIT_TIMES = 3'd4
    } cfg_index_t;

    // Pointers run over twice the ring depth so full and empty differ
    function automatic ptr_t ptr_inc(input ptr_t p);
        ptr_t r;
        r = (p == PTR_W'(PTR_MOD - 1)) ? '0 : p + PTR_W'(1);
        return r;
    endfunction

    function automatic addr_t ptr_index(input ptr_t p);
        ptr_t t;
        t = (p >= PTR_W'(STORE_DEPTH)) ? p - PTR_W'(STORE_DEPTH) : p;
        return t[ADDR_W-1:0];
    endfunction

    function automatic ptr_t ptr_fill(input ptr_t wr, input ptr_t base);
        ptr_t r;
        r = (wr >= base) ? wr - base : wr + PTR_W'(PTR_MOD) - base;
        return r;
    endfunction

endpackage

FILE: hdl/pbecs_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Read-first: a read of the address written in the same cycle returns the old data.
`timescale 1ns / 1ps

module pbecs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

FILE: hdl/polled_bus_echo_checked_sender.sv
// Top level of the polled bus echo-checked sender: event decode, send ring, echo check.
// Depends on pbecs_pkg and pbecs_ram.
`timescale 1ns / 1ps

// Usage
//   s_ channel: one event per transaction. tuser = {rx_fault, op}, tdata = data byte,
//   tlast = frame_end of a received byte.
//   m_ channel: exactly one result per event, in event order. tdata holds send_byte,
//   pass_byte and eop_source; tuser holds the valid flags, lamp, break, phase and
//   event code; tlast is pass_frame_end.
//   cfg channel: cfg_index selects own_address (0), ack_code (1), nack_code (2),
//   timeout_ticks (3) or break_bit_times (4); other indexes are dropped. cfg_ready is
//   always high. Write only while no event is in flight.
// Timing
//   An event is held in the input register and its result is registered in the result
//   register once that register is free. One event per cycle is sustained while
//   m_tready stays high; the limit is the single state update per cycle, and the send
//   ring read is prefetched from the next read pointer so it does not hold up the flow.
// Reset and stall
//   aresetn low (synchronous) returns to receive with an empty ring and the register
//   defaults. While m_tready is low the result register holds, the input register
//   still takes one more event, and then s_tready drops until the result is taken.

module polled_bus_echo_checked_sender (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [pbecs_pkg::S_TDATA_W-1:0] s_tdata,   // [7:0] data
    input  logic [pbecs_pkg::S_TUSER_W-1:0] s_tuser,   // [2:0] op, [3] rx_fault
    input  logic                            s_tlast,   // frame_end
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [pbecs_pkg::M_TDATA_W-1:0] m_tdata,   // [7:0] send_byte,
                                                       // [15:8] pass_byte,
                                                       // [22:16] eop_source, [23] zero
    output logic [pbecs_pkg::M_TUSER_W-1:0] m_tuser,   // [0] send_valid, [1] pass_valid,
                                                       // [2] pass_error, [3] eop_valid,
                                                       // [4] tx_led, [5] line_break,
                                                       // [8:6] phase, [11:9] event_res
    output logic                            m_tlast,   // pass_frame_end
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [2:0]                      cfg_index,
    input  logic [7:0]                      cfg_data
);

    // Configuration
    logic [6:0] own_address_reg;
    logic [7:0] ack_code_reg;
    logic [7:0] nack_code_reg;
    logic [7:0] timeout_ticks_reg;
    logic [7:0] break_bit_times_reg;

    // Input register
    logic             in_valid_reg;
    pbecs_pkg::op_t   in_op_reg;
    logic [7:0]       in_data_reg;
    logic             in_frame_end_reg;
    logic             in_fault_reg;

    // Block state
    pbecs_pkg::phase_t phase_reg,         phase_next;
    logic [7:0]        break_count_reg,   break_count_next;
    logic [7:0]        timeout_count_reg, timeout_count_next;
    pbecs_pkg::ptr_t   read_ptr_reg,      read_ptr_next;
    pbecs_pkg::ptr_t   write_ptr_reg,     write_ptr_next;
    pbecs_pkg::ptr_t   pkt_start_reg,     pkt_start_next;
    logic [7:0]        echo_expect_reg,   echo_expect_next;
    logic [6:0]        dest_reg,          dest_next;
    pbecs_pkg::wait_t  wait_mode_reg,     wait_mode_next;
    logic              self_poll_reg,     self_poll_next;
    logic              led_reg,           led_next;

    // Result register
    logic                            m_tvalid_reg;
    logic [pbecs_pkg::M_TDATA_W-1:0] m_tdata_reg,  m_tdata_next;
    logic [pbecs_pkg::M_TUSER_W-1:0] m_tuser_reg,  m_tuser_next;
    logic                            m_tlast_reg,  m_tlast_next;

    // Send ring read path
    logic [7:0]          ram_rdata;
    logic                byp_reg;
    logic [7:0]          byp_data_reg;
    logic [7:0]          ring_byte;
    logic                ram_we;
    pbecs_pkg::addr_t    ram_waddr;
    pbecs_pkg::addr_t    ram_raddr;

    // Event decode
    logic                s_accept;
    logic                out_free;
    logic                advance;
    logic                poll_req;
    logic [7:0]          poll_addr;
    logic                poll_hit;
    logic                ack_hit;
    logic                ring_full;
    pbecs_pkg::ptr_t     fill_base;
    pbecs_pkg::event_t   ev;
    logic                send_valid;
    logic [7:0]          send_byte;
    logic                pass_valid;
    logic                eop_valid;
    logic [6:0]          eop_source;

    assign cfg_ready = 1'b1;
    assign out_free  = !m_tvalid_reg || m_tready;
    assign advance   = in_valid_reg && out_free;
    assign s_tready  = !in_valid_reg || out_free;
    assign s_accept  = s_tvalid && s_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            own_address_reg     <= 7'd11;
            ack_code_reg        <= 8'd1;
            nack_code_reg       <= 8'd4;
            timeout_ticks_reg   <= 8'd10;
            break_bit_times_reg <= 8'd11;
        end else if (cfg_valid) begin
            unique case (pbecs_pkg::cfg_index_t'(cfg_index))
                pbecs_pkg::CFG_OWN_ADDRESS:     own_address_reg     <= cfg_data[6:0];
                pbecs_pkg::CFG_ACK_CODE:        ack_code_reg        <= cfg_data;
                pbecs_pkg::CFG_NACK_CODE:       nack_code_reg       <= cfg_data;
                pbecs_pkg::CFG_TIMEOUT_TICKS:   timeout_ticks_reg   <= cfg_data;
                pbecs_pkg::CFG_BREAK_BIT_TIMES: break_bit_times_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // Input register: take a new event whenever it is empty or the held one moves on
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_accept) begin
            in_valid_reg <= 1'b1;
        end else if (advance) begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            in_op_reg        <= pbecs_pkg::op_t'(s_tuser[2:0]);
            in_data_reg      <= s_tdata[7:0];
            in_frame_end_reg <= s_tlast;
            in_fault_reg     <= s_tuser[3];
        end
    end

    // Send ring; the read address tracks the pointer the next event will see
    assign ram_waddr = pbecs_pkg::ptr_index(write_ptr_reg);
    assign ram_raddr = pbecs_pkg::ptr_index(advance ? read_ptr_next : read_ptr_reg);

    pbecs_ram #(
        .WIDTH (8),
        .DEPTH (pbecs_pkg::STORE_DEPTH)
    ) u_send_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (in_data_reg),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Forward a byte written to the slot being fetched in the same cycle
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            byp_reg <= 1'b0;
        end else begin
            byp_reg <= ram_we && (ram_waddr == ram_raddr);
        end
    end

    always_ff @(posedge aclk) begin
        byp_data_reg <= in_data_reg;
    end

    assign ring_byte = byp_reg ? byp_data_reg : ram_rdata;

    assign fill_base = (phase_reg == pbecs_pkg::PH_RX) ? read_ptr_reg : pkt_start_reg;
    assign ring_full = pbecs_pkg::ptr_fill(write_ptr_reg, fill_base)
                       >= pbecs_pkg::PTR_W'(pbecs_pkg::STORE_DEPTH);
    assign ram_we    = advance && (in_op_reg == pbecs_pkg::OP_LOAD) && !ring_full;

    // Poll check in receive, shared by poll reports and a pending self poll
    assign poll_req  = (phase_reg == pbecs_pkg::PH_RX)
                       && ((in_op_reg == pbecs_pkg::OP_POLL)
                           || ((in_op_reg == pbecs_pkg::OP_RX_BYTE) && self_poll_reg));
    assign poll_addr = (in_op_reg == pbecs_pkg::OP_POLL) ? in_data_reg
                                                          : (pbecs_pkg::REQ_BIT | {1'b0, own_address_reg});
    assign ack_hit   = (wait_mode_reg == pbecs_pkg::WAIT_ACK)
                       && ((poll_addr == ack_code_reg) || (poll_addr == nack_code_reg));
    assign poll_hit  = ack_hit || (poll_addr == (pbecs_pkg::REQ_BIT | {1'b0, own_address_reg}));

    always_comb begin
        phase_next         = phase_reg;
        break_count_next   = break_count_reg;
        timeout_count_next = timeout_count_reg;
        read_ptr_next      = read_ptr_reg;
        write_ptr_next     = write_ptr_reg;
        pkt_start_next     = pkt_start_reg;
        echo_expect_next   = echo_expect_reg;
        dest_next          = dest_reg;
        wait_mode_next     = wait_mode_reg;
        self_poll_next     = self_poll_reg;
        led_next           = led_reg;
        ev                 = pbecs_pkg::EV_NONE;
        send_valid         = 1'b0;
        send_byte          = 8'd0;
        pass_valid         = 1'b0;
        eop_valid          = 1'b0;
        eop_source         = 7'd0;

        if (poll_req) begin
            self_poll_next = 1'b0;
            if (poll_hit) begin
                wait_mode_next = pbecs_pkg::WAIT_NONE;
                phase_next     = pbecs_pkg::PH_TX_ADDR;
                pkt_start_next = read_ptr_reg;
                ev             = pbecs_pkg::EV_POLLED;
            end
            if (ack_hit) begin
                ev         = (poll_addr == ack_code_reg) ? pbecs_pkg::EV_ACK
                                                         : pbecs_pkg::EV_NACK;
                eop_valid  = 1'b1;
                eop_source = dest_reg;
            end
        end

        case (in_op_reg)
            pbecs_pkg::OP_LOAD: begin
                if (ring_full) begin
                    ev = pbecs_pkg::EV_DROPPED;
                end else begin
                    write_ptr_next = pbecs_pkg::ptr_inc(write_ptr_reg);
                end
            end
            pbecs_pkg::OP_RX_BYTE: begin
                if (phase_reg == pbecs_pkg::PH_ADDR_ECHO
                        || phase_reg == pbecs_pkg::PH_DATA_ECHO) begin
                    timeout_count_next = 8'd0;
                    if (in_data_reg != echo_expect_reg) begin
                        // rewind to the packet start and break the line
                        read_ptr_next    = pkt_start_reg;
                        break_count_next = break_bit_times_reg;
                        phase_next       = pbecs_pkg::PH_BREAK;
                        ev               = pbecs_pkg::EV_MISMATCH;
                    end else begin
                        phase_next = pbecs_pkg::PH_TX_DATA;
                    end
                end else if (phase_reg == pbecs_pkg::PH_RX) begin
                    pass_valid = 1'b1;
                end
            end
            pbecs_pkg::OP_POLL: begin
                // handled by the poll check above
            end
            pbecs_pkg::OP_TX_READY: begin
                if (phase_reg == pbecs_pkg::PH_TX_ADDR) begin
                    send_valid         = 1'b1;
                    send_byte          = {1'b0, own_address_reg};
                    echo_expect_next   = {1'b0, own_address_reg};
                    phase_next         = pbecs_pkg::PH_ADDR_ECHO;
                    timeout_count_next = timeout_ticks_reg;
                    pkt_start_next     = read_ptr_reg;
                end else if (phase_reg == pbecs_pkg::PH_TX_DATA
                        && read_ptr_reg != write_ptr_reg) begin
                    if (read_ptr_reg == pkt_start_reg) begin
                        // first data byte picks the wait mode and destination
                        wait_mode_next = ring_byte[7] ? pbecs_pkg::WAIT_RESPONSE
                                                      : pbecs_pkg::WAIT_ACK;
                        dest_next      = ring_byte[6:0];
                        led_next       = 1'b1;
                    end
                    read_ptr_next      = pbecs_pkg::ptr_inc(read_ptr_reg);
                    echo_expect_next   = ring_byte;
                    send_valid         = 1'b1;
                    send_byte          = ring_byte;
                    phase_next         = pbecs_pkg::PH_DATA_ECHO;
                    timeout_count_next = timeout_ticks_reg;
                end
            end
            pbecs_pkg::OP_TX_DONE: begin
                if (phase_reg == pbecs_pkg::PH_TX_DATA) begin
                    break_count_next = break_bit_times_reg;
                    phase_next       = pbecs_pkg::PH_BREAK;
                end
            end
            pbecs_pkg::OP_BIT_TICK: begin
                if (phase_reg == pbecs_pkg::PH_BREAK) begin
                    if (break_count_reg <= 8'd1) begin
                        break_count_next   = 8'd0;
                        timeout_count_next = 8'd0;
                        led_next           = 1'b0;
                        phase_next         = pbecs_pkg::PH_RX;
                    end else begin
                        break_count_next = break_count_reg - 8'd1;
                    end
                end
            end
            pbecs_pkg::OP_SLOW_TICK: begin
                if (timeout_count_reg != 8'd0) begin
                    timeout_count_next = timeout_count_reg - 8'd1;
                    if (timeout_count_reg == 8'd1) begin
                        led_next   = 1'b0;
                        phase_next = pbecs_pkg::PH_RX;
                        ev         = pbecs_pkg::EV_TIMEOUT;
                    end
                end
            end
            pbecs_pkg::OP_RESPONSE: begin
                if (wait_mode_reg == pbecs_pkg::WAIT_RESPONSE) begin
                    self_poll_next = 1'b1;
                    wait_mode_next = pbecs_pkg::WAIT_NONE;
                end
            end
            default: ;
        endcase

        m_tdata_next = {1'b0, eop_source,
                        pass_valid ? in_data_reg : 8'd0,
                        send_byte};
        m_tuser_next = {ev, phase_next,
                        phase_next == pbecs_pkg::PH_BREAK,
                        led_next, eop_valid,
                        pass_valid && in_fault_reg,
                        pass_valid, send_valid};
        m_tlast_next = pass_valid && in_frame_end_reg;
    end

    // State register: commit one event per advance
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg         <= pbecs_pkg::PH_RX;
            break_count_reg   <= 8'd0;
            timeout_count_reg <= 8'd0;
            read_ptr_reg      <= '0;
            write_ptr_reg     <= '0;
            pkt_start_reg     <= '0;
            echo_expect_reg   <= 8'd0;
            dest_reg          <= 7'd0;
            wait_mode_reg     <= pbecs_pkg::WAIT_NONE;
            self_poll_reg     <= 1'b0;
            led_reg           <= 1'b0;
        end else if (advance) begin
            phase_reg         <= phase_next;
            break_count_reg   <= break_count_next;
            timeout_count_reg <= timeout_count_next;
            read_ptr_reg      <= read_ptr_next;
            write_ptr_reg     <= write_ptr_next;
            pkt_start_reg     <= pkt_start_next;
            echo_expect_reg   <= echo_expect_next;
            dest_reg          <= dest_next;
            wait_mode_reg     <= wait_mode_next;
            self_poll_reg     <= self_poll_next;
            led_reg           <= led_next;
        end
    end

    // Result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (advance) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            m_tdata_reg <= m_tdata_next;
            m_tuser_reg <= m_tuser_next;
            m_tlast_reg <= m_tlast_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;
    assign m_tlast  = m_tlast_reg;

endmodule

FILE: hdl/pbecs_checker.sv
// Port-level checker for the polled bus echo-checked sender, bound to the top level.
// Depends on pbecs_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module pbecs_checker (
    input logic                            aclk,
    input logic                            aresetn,
    input logic                            m_tvalid,
    input logic                            m_tready,
    input logic [pbecs_pkg::M_TDATA_W-1:0] m_tdata,
    input logic [pbecs_pkg::M_TUSER_W-1:0] m_tuser,
    input logic                            m_tlast
);

    // A stalled result holds
    `ASSERT_NEXT(a_stall_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser))

    // Break line follows the break phase
    `ASSERT_SAME(a_break_phase, aclk, aresetn, m_tvalid, m_tuser[5] == (m_tuser[8:6] == pbecs_pkg::PH_BREAK))

    // A byte is never sent and forwarded by the same event
    `ASSERT_SAME(a_send_or_pass, aclk, aresetn, m_tvalid, !(m_tuser[0] && m_tuser[1]))

    // End of packet comes only with an ack or nack that starts a new transmission
    `ASSERT_SAME(a_eop_event, aclk, aresetn, m_tvalid && m_tuser[3], (m_tuser[11:9] == pbecs_pkg::EV_ACK || m_tuser[11:9] == pbecs_pkg::EV_NACK) && m_tuser[8:6] == pbecs_pkg::PH_TX_ADDR)

    // Forwarded-byte fields are clear when nothing is forwarded
    `ASSERT_SAME(a_pass_clear, aclk, aresetn, m_tvalid && !m_tuser[1], m_tdata[15:8] == 8'd0 && !m_tlast && !m_tuser[2])

endmodule

bind polled_bus_echo_checked_sender pbecs_checker u_pbecs_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);

FILE: tb/polled_bus_echo_checked_sender_tb.sv
// Self-checking bench for the polled bus echo-checked sender: directed script, then random
// event traffic under four idle/stall mixes. Depends on pbecs_pkg and the top level only.
`timescale 1ns / 1ps

module polled_bus_echo_checked_sender_tb;
    import pbecs_pkg::*;

    localparam int unsigned CYCLE_LIMIT      = 300000;
    localparam int unsigned RANDOM_PER_PHASE = 180;
    localparam logic [2:0]  CFG_FIRST_UNUSED = 3'd5;

    typedef struct packed {
        op_t        op;
        logic [7:0] data;
        logic       fe;
        logic       fault;
    } bus_event_t;

    typedef struct packed {
        logic       send_valid;
        logic [7:0] send_byte;
        logic       pass_valid;
        logic [7:0] pass_byte;
        logic       pass_fe;
        logic       pass_err;
        logic       eop_valid;
        logic [6:0] eop_source;
        logic       led;
        logic       brk_line;
        phase_t     phase;
        event_t     ev;
    } node_result_t;

    // pinned rows carry a hand-written phase and event code
    typedef struct packed {
        op_t        op;
        logic [7:0] data;
        logic       fe;
        logic       fault;
        logic [7:0] reps;
        logic       pinned;
        phase_t     phase;
        event_t     ev;
    } script_row_t;

    logic                   aclk      = 1'b0;
    logic                   aresetn   = 1'b0;
    logic                   s_tvalid  = 1'b0;
    logic                   s_tready;
    logic [S_TDATA_W-1:0]   s_tdata   = '0;
    logic [S_TUSER_W-1:0]   s_tuser   = '0;
    logic                   s_tlast   = 1'b0;
    logic                   m_tvalid;
    logic                   m_tready  = 1'b0;
    logic [M_TDATA_W-1:0]   m_tdata;
    logic [M_TUSER_W-1:0]   m_tuser;
    logic                   m_tlast;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [2:0]             cfg_index = '0;
    logic [7:0]             cfg_data  = '0;

    // node model: registers and state
    logic [6:0] reg_own     = 7'd11;
    logic [7:0] reg_ack     = 8'd1;
    logic [7:0] reg_nack    = 8'd4;
    logic [7:0] reg_timeout = 8'd10;
    logic [7:0] reg_break   = 8'd11;

    logic [7:0] ring_bytes [STORE_DEPTH];
    phase_t     node_phase  = PH_RX;
    wait_t      resp_wait   = WAIT_NONE;
    logic [7:0] brk_left    = '0;
    logic [7:0] echo_left   = '0;
    ptr_t       rd_ptr      = '0;
    ptr_t       wr_ptr      = '0;
    ptr_t       pkt_ptr     = '0;
    logic [7:0] echo_byte   = '0;
    logic [6:0] dest_addr   = '0;
    logic       self_poll   = 1'b0;
    logic       lamp        = 1'b0;

    node_result_t node_results_due [$];
    script_row_t  script [$];

    int unsigned send_idle_pct   = 0;
    int unsigned stall_pct       = 0;
    int unsigned fail_count      = 0;
    int unsigned events_sent     = 0;
    int unsigned results_checked = 0;
    int unsigned regs_written    = 0;
    int unsigned cycle_count     = 0;
    int unsigned event_tally [8];

    polled_bus_echo_checked_sender i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),   // [7:0] data
        .s_tuser   (s_tuser),   // [2:0] op, [3] rx_fault
        .s_tlast   (s_tlast),   // frame_end
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),   // [7:0] send_byte, [15:8] pass_byte, [22:16] eop_source
        .m_tuser   (m_tuser),   // [0] send_valid, [1] pass_valid, [2] pass_error,
                                // [3] eop_valid, [4] tx_led, [5] line_break,
                                // [8:6] phase, [11:9] event_res
        .m_tlast   (m_tlast),   // pass_frame_end
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #5 aclk = ~aclk;

    always @(posedge aclk) begin
        m_tready <= ($urandom_range(99) >= stall_pct);
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // Advance the node by one event and return what it must put out
    function automatic node_result_t node_event_step(input bus_event_t e);
        node_result_t r;
        logic [7:0]   poll_addr;
        logic         do_poll;
        logic         hit;
        logic [7:0]   b;
        ptr_t         base;
        ptr_t         fill;
        r = '0;
        r.phase = PH_RX;
        r.ev = EV_NONE;
        do_poll = 1'b0;
        poll_addr = '0;
        case (e.op)
            OP_LOAD: begin
                base = (node_phase == PH_RX) ? rd_ptr : pkt_ptr;
                fill = wr_ptr - base;
                if (fill >= ptr_t'(STORE_DEPTH)) begin
                    r.ev = EV_DROPPED;
                end else begin
                    ring_bytes[wr_ptr[ADDR_W-1:0]] = e.data;
                    wr_ptr = wr_ptr + 1'b1;
                end
            end
            OP_RX_BYTE: begin
                if (node_phase == PH_ADDR_ECHO || node_phase == PH_DATA_ECHO) begin
                    echo_left = '0;
                    if (e.data != echo_byte) begin
                        rd_ptr = pkt_ptr;
                        brk_left = reg_break;
                        node_phase = PH_BREAK;
                        r.ev = EV_MISMATCH;
                    end else begin
                        node_phase = PH_TX_DATA;
                    end
                end else if (node_phase == PH_RX) begin
                    r.pass_valid = 1'b1;
                    r.pass_byte = e.data;
                    r.pass_fe = e.fe;
                    r.pass_err = e.fault;
                    if (self_poll) begin
                        self_poll = 1'b0;
                        do_poll = 1'b1;
                        poll_addr = {1'b1, reg_own};
                    end
                end
            end
            OP_POLL: begin
                if (node_phase == PH_RX) begin
                    self_poll = 1'b0;
                    do_poll = 1'b1;
                    poll_addr = e.data;
                end
            end
            OP_TX_READY: begin
                if (node_phase == PH_TX_ADDR) begin
                    r.send_valid = 1'b1;
                    r.send_byte = {1'b0, reg_own};
                    echo_byte = {1'b0, reg_own};
                    node_phase = PH_ADDR_ECHO;
                    echo_left = reg_timeout;
                    pkt_ptr = rd_ptr;
                end else if (node_phase == PH_TX_DATA && rd_ptr != wr_ptr) begin
                    b = ring_bytes[rd_ptr[ADDR_W-1:0]];
                    // the first data byte decides what reply the node waits for
                    if (rd_ptr == pkt_ptr) begin
                        resp_wait = b[7] ? WAIT_RESPONSE : WAIT_ACK;
                        dest_addr = b[6:0];
                        lamp = 1'b1;
                    end
                    rd_ptr = rd_ptr + 1'b1;
                    echo_byte = b;
                    r.send_valid = 1'b1;
                    r.send_byte = b;
                    node_phase = PH_DATA_ECHO;
                    echo_left = reg_timeout;
                end
            end
            OP_TX_DONE: begin
                if (node_phase == PH_TX_DATA) begin
                    brk_left = reg_break;
                    node_phase = PH_BREAK;
                end
            end
            OP_BIT_TICK: begin
                if (node_phase == PH_BREAK) begin
                    if (brk_left <= 8'd1) begin
                        brk_left = '0;
                        echo_left = '0;
                        lamp = 1'b0;
                        node_phase = PH_RX;
                    end else begin
                        brk_left = brk_left - 1'b1;
                    end
                end
            end
            OP_SLOW_TICK: begin
                if (echo_left != '0) begin
                    echo_left = echo_left - 1'b1;
                    if (echo_left == '0) begin
                        lamp = 1'b0;
                        node_phase = PH_RX;
                        r.ev = EV_TIMEOUT;
                    end
                end
            end
            default: begin
                if (resp_wait == WAIT_RESPONSE) begin
                    self_poll = 1'b1;
                    resp_wait = WAIT_NONE;
                end
            end
        endcase
        if (do_poll) begin
            hit = (poll_addr == {1'b1, reg_own});
            r.ev = EV_POLLED;
            // ack wins when both codes are the same
            if (resp_wait == WAIT_ACK && (poll_addr == reg_ack || poll_addr == reg_nack)) begin
                r.ev = (poll_addr == reg_ack) ? EV_ACK : EV_NACK;
                r.eop_valid = 1'b1;
                r.eop_source = dest_addr;
                hit = 1'b1;
            end
            if (hit) begin
                resp_wait = WAIT_NONE;
                node_phase = PH_TX_ADDR;
                pkt_ptr = rd_ptr;
            end else begin
                r.ev = EV_NONE;
            end
        end
        r.led = lamp;
        r.brk_line = (node_phase == PH_BREAK);
        r.phase = node_phase;
        return r;
    endfunction

    // Mostly the event that moves the current phase along, sometimes noise
    function automatic bus_event_t next_bus_event();
        bus_event_t  e;
        int unsigned pick;
        e.op = op_t'($urandom_range(7));
        e.data = 8'($urandom);
        e.fe = 1'($urandom);
        e.fault = 1'($urandom);
        pick = $urandom_range(99);
        if (pick < 10)
            return e;
        pick = $urandom_range(99);
        case (node_phase)
            PH_RX: begin
                if (resp_wait == WAIT_ACK && pick < 25) begin
                    e.op = OP_POLL;
                    e.data = pick[0] ? reg_ack : reg_nack;
                end else if (resp_wait == WAIT_RESPONSE && pick < 20) begin
                    e.op = OP_RESPONSE;
                end else if (pick < 55) begin
                    e.op = OP_LOAD;
                end else if (pick < 80) begin
                    e.op = OP_POLL;
                    e.data = {1'b1, reg_own};
                end else begin
                    e.op = OP_RX_BYTE;
                end
            end
            PH_TX_ADDR: begin
                e.op = OP_TX_READY;
            end
            PH_ADDR_ECHO, PH_DATA_ECHO: begin
                if (pick < 90) begin
                    e.op = OP_RX_BYTE;
                    if (pick < 86)
                        e.data = echo_byte;
                end else begin
                    e.op = OP_SLOW_TICK;
                end
            end
            PH_TX_DATA: begin
                e.op = (rd_ptr != wr_ptr && pick < 80) ? OP_TX_READY : OP_TX_DONE;
            end
            default: begin
                e.op = OP_BIT_TICK;
            end
        endcase
        return e;
    endfunction

    task automatic send_event(input bus_event_t e, input logic pin = 1'b0,
                              input phase_t pin_phase = PH_RX, input event_t pin_ev = EV_NONE);
        node_result_t r;
        s_tvalid <= 1'b1;
        s_tdata <= e.data;
        s_tuser <= {e.fault, e.op};
        s_tlast <= e.fe;
        do @(posedge aclk); while (!s_tready);
        r = node_event_step(e);
        if (pin) begin
            r.phase = pin_phase;
            r.ev = pin_ev;
        end
        node_results_due.push_back(r);
        event_tally[r.ev]++;
        events_sent++;
        // hold valid high when the next transaction follows at once
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
    endtask

    task automatic wait_for_results();
        s_tvalid <= 1'b0;
        while (node_results_due.size() != 0)
            @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [7:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do @(posedge aclk); while (!cfg_ready);
        case (idx)
            CFG_OWN_ADDRESS:     reg_own = val[6:0];
            CFG_ACK_CODE:        reg_ack = val;
            CFG_NACK_CODE:       reg_nack = val;
            CFG_TIMEOUT_TICKS:   reg_timeout = val;
            CFG_BREAK_BIT_TIMES: reg_break = val;
            default: ;
        endcase
        regs_written++;
        cfg_valid <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic program_regs(input logic [6:0] own, input logic [7:0] ack,
                                input logic [7:0] nack, input logic [7:0] tmo,
                                input logic [7:0] brk);
        wait_for_results();
        write_reg(CFG_OWN_ADDRESS, {1'b0, own});
        write_reg(CFG_ACK_CODE, ack);
        write_reg(CFG_NACK_CODE, nack);
        write_reg(CFG_TIMEOUT_TICKS, tmo);
        write_reg(CFG_BREAK_BIT_TIMES, brk);
        // unused indexes must leave every register alone
        write_reg(CFG_FIRST_UNUSED + 3'($urandom_range(2)), 8'($urandom));
    endtask

    task automatic add_row(input op_t op, input logic [7:0] data, input logic fe,
                           input logic fault, input logic [7:0] reps, input logic pinned,
                           input phase_t ph, input event_t ev);
        script.push_back('{op, data, fe, fault, reps, pinned, ph, ev});
    endtask

    task automatic check_field(input string name, input logic [7:0] want,
                               input logic [7:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            fail_count++;
        end
    endtask

    always @(posedge aclk) begin : result_monitor
        node_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (node_results_due.size() == 0) begin
                $error("result transaction with no event outstanding");
                fail_count++;
            end else begin
                want = node_results_due.pop_front();
                check_field("send_valid", want.send_valid, m_tuser[0]);
                check_field("send_byte", want.send_byte, m_tdata[7:0]);
                check_field("pass_valid", want.pass_valid, m_tuser[1]);
                check_field("pass_byte", want.pass_byte, m_tdata[15:8]);
                check_field("pass_frame_end", want.pass_fe, m_tlast);
                check_field("pass_error", want.pass_err, m_tuser[2]);
                check_field("eop_valid", want.eop_valid, m_tuser[3]);
                check_field("eop_source", want.eop_source, m_tdata[22:16]);
                check_field("tx_led", want.led, m_tuser[4]);
                check_field("line_break", want.brk_line, m_tuser[5]);
                check_field("phase", want.phase, m_tuser[8:6]);
                check_field("event_res", want.ev, m_tuser[11:9]);
                results_checked++;
            end
        end
    end

    initial begin
        bus_event_t  e;
        script_row_t row;
        int          n;
        int          k;
        int          p;
        int          i;

        foreach (ring_bytes[j])
            ring_bytes[j] = '0;
        foreach (event_tally[j])
            event_tally[j] = 0;

        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // short timers keep the script compact
        program_regs(7'd11, 8'd1, 8'd4, 8'd1, 8'd1);

        add_row(OP_TX_READY,  8'h00, 1'b0, 1'b0, 1,  1'b1, PH_RX,        EV_NONE);
        add_row(OP_TX_DONE,   8'h00, 1'b0, 1'b0, 1,  1'b1, PH_RX,        EV_NONE);
        add_row(OP_BIT_TICK,  8'h00, 1'b0, 1'b0, 1,  1'b1, PH_RX,        EV_NONE);
        add_row(OP_SLOW_TICK, 8'h00, 1'b0, 1'b0, 1,  1'b1, PH_RX,        EV_NONE);
        add_row(OP_RESPONSE,  8'h00, 1'b0, 1'b0, 1,  1'b1, PH_RX,        EV_NONE);
        add_row(OP_RX_BYTE,   8'hFF, 1'b1, 1'b1, 1,  1'b1, PH_RX,        EV_NONE);
        add_row(OP_RX_BYTE,   8'h00, 1'b0, 1'b0, 1,  1'b1, PH_RX,        EV_NONE);
        add_row(OP_LOAD,      8'h85, 1'b0, 1'b0, 1,  1'b1, PH_RX,        EV_NONE);
        add_row(OP_LOAD,      8'h7F, 1'b0, 1'b0, 1,  1'b1, PH_RX,        EV_NONE);
        add_row(OP_POLL,      8'h0B, 1'b0, 1'b0, 1,  1'b1, PH_RX,        EV_NONE);
        add_row(OP_POLL,      8'hFF, 1'b0, 1'b0, 1,  1'b1, PH_RX,        EV_NONE);
        add_row(OP_POLL,      8'h8B, 1'b0, 1'b0, 1,  1'b1, PH_TX_ADDR,   EV_POLLED);
        add_row(OP_RX_BYTE,   8'h33, 1'b1, 1'b0, 1,  1'b1, PH_TX_ADDR,   EV_NONE);
        add_row(OP_TX_READY,  8'h00, 1'b0, 1'b0, 1,  1'b1, PH_ADDR_ECHO, EV_NONE);
        add_row(OP_RX_BYTE,   8'h0B, 1'b1, 1'b1, 1,  1'b1, PH_TX_DATA,   EV_NONE);
        add_row(OP_TX_READY,  8'h00, 1'b0, 1'b0, 1,  1'b1, PH_DATA_ECHO, EV_NONE);
        add_row(OP_RX_BYTE,   8'h84, 1'b0, 1'b0, 1,  1'b1, PH_BREAK,     EV_MISMATCH);
        add_row(OP_BIT_TICK,  8'h00, 1'b0, 1'b0, 1,  1'b1, PH_RX,        EV_NONE);
        add_row(OP_RESPONSE,  8'h00, 1'b0, 1'b0, 1,  1'b1, PH_RX,        EV_NONE);
        add_row(OP_RX_BYTE,   8'h10, 1'b0, 1'b1, 1,  1'b1, PH_TX_ADDR,   EV_POLLED);
        add_row(OP_TX_READY,  8'h00, 1'b0, 1'b0, 1,  1'b1, PH_ADDR_ECHO, EV_NONE);
        add_row(OP_SLOW_TICK, 8'h00, 1'b0, 1'b0, 1,  1'b1, PH_RX,        EV_TIMEOUT);
        add_row(OP_LOAD,      8'h5A, 1'b0, 1'b0, 62, 1'b1, PH_RX,        EV_NONE);
        add_row(OP_LOAD,      8'hAA, 1'b0, 1'b0, 1,  1'b1, PH_RX,        EV_DROPPED);

        for (n = 0; n < script.size(); n++) begin
            row = script[n];
            for (k = 0; k < row.reps; k++) begin
                e.op = row.op;
                e.data = row.data;
                e.fe = row.fe;
                e.fault = row.fault;
                send_event(e, row.pinned, row.phase, row.ev);
            end
        end

        for (p = 0; p < 4; p++) begin
            case (p)
                0: begin
                    program_regs(7'h7F, 8'h00, 8'hFF, 8'd0, 8'd0);
                    send_idle_pct = 0;
                    stall_pct = 0;
                end
                1: begin
                    program_regs(7'h00, 8'hFF, 8'h00, 8'd255, 8'd3);
                    send_idle_pct = 82;
                    stall_pct = 0;
                end
                2: begin
                    program_regs(7'h0B, 8'h22, 8'h22, 8'd1, 8'd2);
                    send_idle_pct = 0;
                    stall_pct = 82;
                end
                default: begin
                    program_regs(7'h55, 8'h01, 8'h04, 8'd3, 8'd255);
                    send_idle_pct = 32;
                    stall_pct = 32;
                end
            endcase
            for (i = 0; i < RANDOM_PER_PHASE; i++) begin
                send_event(next_bus_event());
                // now and then let the node run dry before going on
                if ($urandom_range(199) == 0)
                    wait_for_results();
            end
        end

        wait_for_results();
        $display("Sent %0d events and %0d register writes, checked %0d results.",
                 events_sent, regs_written, results_checked);
        $display("Events: polled %0d, ack %0d, nack %0d, mismatch %0d, timeout %0d, drop %0d",
                 event_tally[EV_POLLED], event_tally[EV_ACK], event_tally[EV_NACK],
                 event_tally[EV_MISMATCH], event_tally[EV_TIMEOUT], event_tally[EV_DROPPED]);
        if (fail_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
